// File: hw/rtl/cfcc_pkg.sv
// ---------------------------------------------------------------------------
// cfcc_pkg: shared types and constants
// Codes, field widths and command/status structs for the chain checker.
// ---------------------------------------------------------------------------
package cfcc_pkg;

  localparam int BLOCK_SIZE_DEF = 512;
  localparam int DIR_BLOCKS_DEF = 16;
  localparam int DIR_DEPTH      = 8192;

  localparam logic [7:0]  MARK_BYTE = 8'h55;
  localparam logic [15:0] FREE_MARK = 16'hfffc;
  localparam logic [15:0] END_MARK  = 16'hfffa;
  localparam logic [7:0]  TYPE_A    = 8'h33;
  localparam logic [7:0]  TYPE_B    = 8'hcc;
  localparam logic [15:0] BLOCK_CEIL = 16'd255;

  typedef enum logic [1:0] {
    OP_ROOT  = 2'd0,
    OP_TABLE = 2'd1,
    OP_DIR   = 2'd2,
    OP_CHECK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNFORMAT = 3'd1,
    ST_LAYOUT   = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_CHAIN    = 3'd4,
    ST_LENGTH   = 3'd5
  } status_t;

  // Read port selection for the datapath.
  typedef enum logic [1:0] {
    RS_ROOT  = 2'd0,
    RS_TABLE = 2'd1,
    RS_DIR   = 2'd2
  } rsel_t;

  // Datapath registers that take the read word.
  typedef enum logic [3:0] {
    LD_NONE   = 4'd0,
    LD_MARK   = 4'd1,
    LD_TPOS   = 4'd2,
    LD_TCOUNT = 4'd3,
    LD_DSTART = 4'd4,
    LD_DLEN   = 4'd5,
    LD_USERS  = 4'd6,
    LD_FREE   = 4'd7,
    LD_KIND   = 4'd8,
    LD_BLOCKS = 4'd9,
    LD_AT     = 4'd10,
    LD_HDR    = 4'd11,
    LD_NEXT   = 4'd12
  } ld_t;

  typedef struct packed {
    logic        rd_en;
    rsel_t       rsel;
    logic [12:0] raddr;
    ld_t         ld;
    logic        clr_map;
    logic [7:0]  clr_idx;
    logic        set_map;
    logic        clr_totals;
    logic        inc_entry;
  } cmd_t;

  typedef struct packed {
    logic        mark_ok;
    logic        layout_ok;
    logic        entry_ok;
    logic        kind_zero;
    logic        at_bad;
    logic        next_end;
    logic [15:0] users;
    logic [15:0] dlen;
    logic [15:0] blocks;
    logic [15:0] at;
    logic [8:0]  entry_total;
    logic [7:0]  free_total;
  } stat_t;

endpackage

// File: hw/rtl/cfcc_if.sv
// ---------------------------------------------------------------------------
// cfcc_in_if / cfcc_out_if: valid/ready channels
// Input command channel and result channel of the chain checker.
// ---------------------------------------------------------------------------
interface cfcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [12:0] offset;
  logic [7:0]  byte_value;
  modport source (output valid, opcode, offset, byte_value, input ready);
  modport sink (input valid, opcode, offset, byte_value, output ready);
endinterface

interface cfcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [8:0] save_count;
  logic [7:0] free_count;
  modport source (output valid, status, save_count, free_count, input ready);
  modport sink (input valid, status, save_count, free_count, output ready);
endinterface

// File: hw/rtl/cfcc_datapath.sv
// ---------------------------------------------------------------------------
// cfcc_datapath: stores, bitmap and check registers
// Holds the byte stores and evaluates the layout, entry and chain tests.
// ---------------------------------------------------------------------------
module cfcc_datapath #(
  parameter int BLOCK_SIZE = 512,
  parameter int DIR_BLOCKS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  cfcc_pkg::op_t      wr_op,
  input  logic [12:0]        wr_addr,
  input  logic [7:0]         wr_data,
  input  cfcc_pkg::cmd_t     cmd,
  output cfcc_pkg::stat_t    stat
);
  import cfcc_pkg::*;

  localparam int AW = $clog2(BLOCK_SIZE);

  logic [7:0] root_mem [BLOCK_SIZE];
  logic [7:0] table_mem [BLOCK_SIZE];
  logic [7:0] dir_mem [DIR_DEPTH];
  logic       map_mem [256];
  logic       map_bit_r;

  logic [7:0] rdata_r;
  logic       rdata_ok_r;
  logic       lo_pend_r;
  ld_t        ld_r;
  logic [7:0] lo_r;
  logic [15:0] tpos_r, tcount_r, dstart_r, dlen_r, users_r;
  logic [15:0] blocks_r, at_r, hdr_r, next_r;
  logic [7:0]  kind_r;
  logic        mark_ok_r;
  logic [8:0]  entry_r;
  logic [7:0]  free_r;
  logic [7:0]  word_b;
  logic [15:0] word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (wr_op)
        OP_ROOT: if (wr_addr < 13'(BLOCK_SIZE)) root_mem[wr_addr[AW-1:0]] <= wr_data;
        OP_TABLE: if (wr_addr < 13'(BLOCK_SIZE)) table_mem[wr_addr[AW-1:0]] <= wr_data;
        OP_DIR: dir_mem[wr_addr] <= wr_data;
        default: ;
      endcase
    end
  end

  // Registered reads: one byte per cycle; addresses beyond a store read zero.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      case (cmd.rsel)
        RS_ROOT: rdata_r <= root_mem[cmd.raddr[AW-1:0]];
        RS_TABLE: rdata_r <= table_mem[cmd.raddr[AW-1:0]];
        default: rdata_r <= dir_mem[cmd.raddr];
      endcase
      rdata_ok_r <= (cmd.rsel == RS_DIR) || (cmd.raddr < 13'(BLOCK_SIZE));
    end
  end

  // The used-block bitmap is cleared entry by entry at the start of each check.
  always_ff @(posedge clk) begin
    if (cmd.clr_map) begin
      map_mem[cmd.clr_idx] <= 1'b0;
    end else if (cmd.set_map) begin
      map_mem[at_r[7:0]] <= 1'b1;
    end
    map_bit_r <= map_mem[at_r[7:0]];
  end

  // A load tag is issued with the high byte read; the low byte is captured before.
  assign word_b = rdata_ok_r ? rdata_r : 8'd0;
  assign word = {word_b, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r <= LD_NONE;
      lo_pend_r <= 1'b0;
      entry_r <= '0;
      free_r <= '0;
      mark_ok_r <= 1'b0;
    end else begin
      ld_r <= cmd.ld;
      lo_pend_r <= cmd.rd_en && cmd.ld == LD_NONE;
      if (lo_pend_r) lo_r <= word_b;
      if (cmd.clr_totals) begin
        entry_r <= '0;
        free_r <= '0;
      end
      if (cmd.inc_entry) entry_r <= entry_r + 9'd1;
      case (ld_r)
        LD_MARK: mark_ok_r <= (word_b == MARK_BYTE);
        LD_TPOS: tpos_r <= word;
        LD_TCOUNT: tcount_r <= word;
        LD_DSTART: dstart_r <= word;
        LD_DLEN: dlen_r <= word;
        LD_USERS: users_r <= word;
        LD_FREE: if (word == FREE_MARK) free_r <= free_r + 8'd1;
        LD_KIND: kind_r <= word_b;
        LD_BLOCKS: blocks_r <= word;
        LD_AT: at_r <= word;
        LD_HDR: hdr_r <= word;
        LD_NEXT: begin
          next_r <= word;
          at_r <= word;
        end
        default: ;
      endcase
    end
  end

  logic [16:0] dtop, dlow;
  assign dtop = {1'b0, dstart_r} + 17'd1;
  assign dlow = dtop - {1'b0, dlen_r};

  always_comb begin
    stat.mark_ok = mark_ok_r;
    stat.layout_ok = !(tcount_r != 16'd1 || tpos_r >= BLOCK_CEIL || dlen_r == 16'd0 ||
      dlen_r > 16'(DIR_BLOCKS) || dstart_r >= BLOCK_CEIL ||
      {1'b0, dlen_r} > dtop || users_r == 16'd0 || users_r > BLOCK_CEIL ||
      tpos_r < users_r || dlow < {1'b0, users_r} ||
      (tpos_r <= dstart_r && {1'b0, tpos_r} >= dlow));
    stat.kind_zero = (kind_r == 8'd0);
    stat.entry_ok = !((kind_r != TYPE_A && kind_r != TYPE_B) || blocks_r == 16'd0 ||
      blocks_r > users_r || hdr_r >= blocks_r);
    stat.at_bad = (at_r >= users_r) || (at_r > 16'd255) || map_bit_r;
    stat.next_end = (next_r == END_MARK);
    stat.users = users_r;
    stat.dlen = dlen_r;
    stat.blocks = blocks_r;
    stat.at = at_r;
    stat.entry_total = entry_r;
    stat.free_total = free_r;
  end

endmodule

// File: hw/rtl/cfcc_ctrl.sv
// ---------------------------------------------------------------------------
// cfcc_ctrl: check sequencer
// Steps through marker, layout, free count, entries and chains.
// ---------------------------------------------------------------------------
module cfcc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output logic [2:0]        result,
  input  logic              res_taken,
  output cfcc_pkg::cmd_t    cmd,
  input  cfcc_pkg::stat_t   stat
);
  import cfcc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLR   = 10'b0000000010,
    S_MARK  = 10'b0000000100,
    S_ROOT  = 10'b0000001000,
    S_FREE  = 10'b0000010000,
    S_ENT   = 10'b0000100000,
    S_WALK  = 10'b0001000000,
    S_NEXT  = 10'b0010000000,
    S_WAIT  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [3:0]  sub_r, sub_nxt;
  logic [15:0] n_r, n_nxt;
  logic [2:0]  res_r, res_nxt;

  logic [12:0] base;
  assign base = {cnt_r[7:0], 5'd0};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    sub_nxt = sub_r;
    n_nxt = n_r;
    res_nxt = res_r;
    cmd = '0;
    cmd.rsel = RS_ROOT;
    cmd.ld = LD_NONE;
    case (state_r)
      S_IDLE: if (start) begin
        state_nxt = S_CLR;
        cnt_nxt = '0;
      end
      S_CLR: begin
        cmd.clr_map = 1'b1;
        cmd.clr_idx = cnt_r[7:0];
        cmd.clr_totals = 1'b1;
        cnt_nxt = cnt_r + 9'd1;
        if (cnt_r == 9'd255) begin
          cnt_nxt = '0;
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (sub_r == 4'd0) begin
          cmd.rd_en = 1'b1;
          cmd.raddr = 13'(cnt_r);
          cmd.ld = LD_MARK;
          sub_nxt = 4'd1;
        end else if (sub_r == 4'd1) begin
          sub_nxt = 4'd2;
        end else begin
          sub_nxt = 4'd0;
          if (!stat.mark_ok) begin
            res_nxt = ST_UNFORMAT;
            state_nxt = S_DONE;
          end else if (cnt_r == 9'd15) begin
            cnt_nxt = '0;
            state_nxt = S_ROOT;
          end else cnt_nxt = cnt_r + 9'd1;
        end
      end
      S_ROOT: begin
        // Per field: low byte, high byte with tag, settle.
        if (cnt_r < 9'd5) begin
          cmd.rd_en = (sub_r != 4'd2);
          cmd.raddr = (cnt_r == 9'd4) ? 13'd80 : 13'(70 + 2 * cnt_r);
          if (sub_r == 4'd1) begin
            cmd.raddr = cmd.raddr + 13'd1;
            case (cnt_r)
              9'd0: cmd.ld = LD_TPOS;
              9'd1: cmd.ld = LD_TCOUNT;
              9'd2: cmd.ld = LD_DSTART;
              9'd3: cmd.ld = LD_DLEN;
              default: cmd.ld = LD_USERS;
            endcase
          end
          if (sub_r == 4'd2) begin
            sub_nxt = 4'd0;
            cnt_nxt = cnt_r + 9'd1;
          end else sub_nxt = sub_r + 4'd1;
        end else if (sub_r == 4'd0) begin
          sub_nxt = 4'd1;
        end else begin
          sub_nxt = 4'd0;
          cnt_nxt = '0;
          if (!stat.layout_ok) begin
            res_nxt = ST_LAYOUT;
            state_nxt = S_DONE;
          end else state_nxt = S_FREE;
        end
      end
      S_FREE: begin
        if ({7'd0, cnt_r} >= stat.users && sub_r == 4'd0) begin
          cnt_nxt = '0;
          state_nxt = S_ENT;
        end else begin
          cmd.rsel = RS_TABLE;
          cmd.rd_en = (sub_r != 4'd2);
          cmd.raddr = {3'd0, cnt_r, 1'b0} + 13'(sub_r[0]);
          if (sub_r == 4'd1) cmd.ld = LD_FREE;
          if (sub_r == 4'd2) begin
            sub_nxt = 4'd0;
            cnt_nxt = cnt_r + 9'd1;
          end else sub_nxt = sub_r + 4'd1;
        end
      end
      S_ENT: begin
        cmd.rsel = RS_DIR;
        case (sub_r)
          4'd0: begin
            if ({7'd0, cnt_r} >= {stat.dlen[11:0], 4'd0}) begin
              res_nxt = ST_OK;
              state_nxt = S_DONE;
            end else begin
              cmd.rd_en = 1'b1;
              cmd.raddr = base;
              cmd.ld = LD_KIND;
              sub_nxt = 4'd1;
            end
          end
          4'd1: sub_nxt = 4'd2;
          4'd2: begin
            cmd.rd_en = 1'b1;
            cmd.raddr = base + 13'd24;
            sub_nxt = 4'd3;
            if (stat.kind_zero) begin
              cmd.rd_en = 1'b0;
              sub_nxt = 4'd0;
              cnt_nxt = cnt_r + 9'd1;
            end
          end
          4'd3: begin
            cmd.rd_en = 1'b1;
            cmd.raddr = base + 13'd25;
            cmd.ld = LD_BLOCKS;
            sub_nxt = 4'd4;
          end
          4'd4: begin
            cmd.rd_en = 1'b1;
            cmd.raddr = base + 13'd26;
            sub_nxt = 4'd5;
          end
          4'd5: begin
            cmd.rd_en = 1'b1;
            cmd.raddr = base + 13'd27;
            cmd.ld = LD_HDR;
            sub_nxt = 4'd6;
          end
          4'd6: begin
            cmd.rd_en = 1'b1;
            cmd.raddr = base + 13'd2;
            sub_nxt = 4'd7;
          end
          4'd7: begin
            cmd.rd_en = 1'b1;
            cmd.raddr = base + 13'd3;
            cmd.ld = LD_AT;
            sub_nxt = 4'd8;
          end
          4'd8: sub_nxt = 4'd9;
          default: begin
            sub_nxt = 4'd0;
            n_nxt = '0;
            if (!stat.entry_ok) begin
              res_nxt = ST_ENTRY;
              state_nxt = S_DONE;
            end else state_nxt = S_WALK;
          end
        endcase
      end
      S_WALK: begin
        cmd.rsel = RS_TABLE;
        case (sub_r)
          4'd0: begin
            if (stat.at_bad) begin
              res_nxt = ST_CHAIN;
              state_nxt = S_DONE;
            end else begin
              cmd.set_map = 1'b1;
              cmd.rd_en = 1'b1;
              cmd.raddr = {4'd0, stat.at[7:0], 1'b0};
              sub_nxt = 4'd1;
            end
          end
          4'd1: begin
            cmd.rd_en = 1'b1;
            cmd.raddr = {4'd0, stat.at[7:0], 1'b1};
            cmd.ld = LD_NEXT;
            sub_nxt = 4'd2;
          end
          4'd2: sub_nxt = 4'd3;
          default: begin
            sub_nxt = 4'd0;
            if (n_r + 16'd1 == stat.blocks) begin
              if (!stat.next_end) begin
                res_nxt = ST_LENGTH;
                state_nxt = S_DONE;
              end else begin
                cmd.inc_entry = 1'b1;
                cnt_nxt = cnt_r + 9'd1;
                state_nxt = S_ENT;
              end
            end else n_nxt = n_r + 16'd1;
          end
        endcase
      end
      S_DONE: begin
        if (res_r != ST_OK) cmd.clr_totals = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: if (res_taken) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      sub_r <= '0;
      n_r <= '0;
      res_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
      n_r <= n_nxt;
      res_r <= res_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_WAIT);
  assign result = res_r;

endmodule

// File: hw/rtl/card_filesystem_chain_checker.sv
// ---------------------------------------------------------------------------
// card_filesystem_chain_checker: memory-card filesystem metadata checker
// Load beats are accepted only while the checker is idle. A check clears the
// bitmap, then reads the marker bytes, root fields, free entries, directory
// entries and chain blocks in turn, all through the single store read port.
// The result beat is held until taken. Reset clears control; the bitmap is
// cleared at the start of every check.
// ---------------------------------------------------------------------------
module card_filesystem_chain_checker #(
  parameter int BLOCK_SIZE = cfcc_pkg::BLOCK_SIZE_DEF,
  parameter int DIR_BLOCKS = cfcc_pkg::DIR_BLOCKS_DEF
) (
  input logic clk,
  input logic rst_n,
  cfcc_in_if.sink    in_ch,
  cfcc_out_if.source out_ch
);
  import cfcc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy, done;
  logic [2:0] result;
  logic  acc;

  assign in_ch.ready = !busy;
  assign acc = in_ch.valid && in_ch.ready;

  cfcc_datapath #(.BLOCK_SIZE(BLOCK_SIZE), .DIR_BLOCKS(DIR_BLOCKS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .wr_en(acc && in_ch.opcode != OP_CHECK),
    .wr_op(op_t'(in_ch.opcode)), .wr_addr(in_ch.offset), .wr_data(in_ch.byte_value),
    .cmd(cmd), .stat(stat)
  );

  cfcc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .start(acc && in_ch.opcode == OP_CHECK),
    .busy(busy), .done(done), .result(result),
    .res_taken(out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  assign out_ch.valid = done;
  assign out_ch.status = result;
  assign out_ch.save_count = stat.entry_total;
  assign out_ch.free_count = stat.free_total;

endmodule

// File: tb/cfcc_tb_if.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cfcc_tb_if: testbench view of the chain checker channels
// The channel interfaces come from the RTL; this file only holds the beat
// record that the driver queue carries and the expected check result record.
// ---------------------------------------------------------------------------
package cfcc_tb_pkg;
  import cfcc_pkg::*;

  typedef struct {
    op_t         op;
    logic [12:0] off;
    logic [7:0]  val;
    int          wait_results;
  } load_beat_t;

  typedef struct {
    status_t    status;
    logic [8:0] save_count;
    logic [7:0] free_count;
  } check_result_t;
endpackage

// File: tb/card_filesystem_chain_checker_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// card_filesystem_chain_checker_tb: self-checking bench for the card checker
// Builds small card images (root, table, directory) with random chains and
// random damage, predicts each check in the bench, and compares every
// result beat under random stalls on both channels.
// ---------------------------------------------------------------------------
module card_filesystem_chain_checker_tb;
  import cfcc_pkg::*;
  import cfcc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  cfcc_in_if  in_ch();
  cfcc_out_if out_ch();

  card_filesystem_chain_checker dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  load_beat_t    beat_q[$];
  check_result_t verdict_q[$];
  int            results_seen = 0;
  int            checks_planned = 0;
  int            beats_planned = 0;
  int            errors = 0;
  int            cycles = 0;
  int            hold_next = 0;

  logic [7:0] root_m [512];
  logic [7:0] table_m [512];
  logic [7:0] dir_m [8192];
  bit         root_w [512];
  bit         table_w [512];
  bit         dir_w [8192];
  bit         used_m [256];
  bit         unwritten_hit;
  int         used_bases[$];

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int byte_at(int store, int pos);
    case (store)
      0: begin
        if (!root_w[pos]) unwritten_hit = 1;
        return root_m[pos];
      end
      1: begin
        if (!table_w[pos]) unwritten_hit = 1;
        return table_m[pos];
      end
      default: begin
        if (!dir_w[pos]) unwritten_hit = 1;
        return dir_m[pos];
      end
    endcase
  endfunction

  function automatic int word_at(int store, int pos);
    return byte_at(store, pos) | (byte_at(store, pos + 1) << 8);
  endfunction

  function automatic void predict_check(output status_t st, output int saves,
                                        output int frees);
    int tpos, tcount, dstart, dlen, users, base, kind, blocks, at, nxt;
    saves = 0;
    frees = 0;
    for (int i = 0; i < 256; i++) used_m[i] = 0;
    for (int i = 0; i < 16; i++)
      if (byte_at(0, i) != MARK_BYTE) begin
        st = ST_UNFORMAT;
        return;
      end
    tpos = word_at(0, 70);
    tcount = word_at(0, 72);
    dstart = word_at(0, 74);
    dlen = word_at(0, 76);
    users = word_at(0, 80);
    if (tcount != 1 || tpos >= 255 || dlen == 0 || dlen > 16 || dstart >= 255 ||
        dlen > dstart + 1 || users == 0 || users > 255 || tpos < users ||
        dstart + 1 - dlen < users || (tpos <= dstart && tpos >= dstart + 1 - dlen)) begin
      st = ST_LAYOUT;
      return;
    end
    for (int i = 0; i < users; i++)
      if (word_at(1, i * 2) == FREE_MARK) frees++;
    for (int i = 0; i < dlen * 16; i++) begin
      base = i * 32;
      kind = byte_at(2, base);
      if (kind != 0) begin
        blocks = word_at(2, base + 24);
        at = word_at(2, base + 2);
        if ((kind != TYPE_A && kind != TYPE_B) || blocks == 0 || blocks > users ||
            word_at(2, base + 26) >= blocks) begin
          st = ST_ENTRY;
          saves = 0;
          frees = 0;
          return;
        end
        for (int n = 0; n < blocks; n++) begin
          if (at >= users || used_m[at]) begin
            st = ST_CHAIN;
            saves = 0;
            frees = 0;
            return;
          end
          used_m[at] = 1;
          nxt = word_at(1, at * 2);
          if (n + 1 == blocks) begin
            if (nxt != END_MARK) begin
              st = ST_LENGTH;
              saves = 0;
              frees = 0;
              return;
            end
          end else begin
            at = nxt;
          end
        end
        saves++;
      end
    end
    st = ST_OK;
  endfunction

  task automatic send(op_t op, int off, int val);
    load_beat_t b;
    int o;
    o = off & 32'h1fff;
    b.op = op;
    b.off = o[12:0];
    b.val = val[7:0];
    b.wait_results = hold_next ? checks_planned : 0;
    hold_next = 0;
    case (op)
      OP_ROOT: if (o < 512) begin root_m[o] = val[7:0]; root_w[o] = 1; end
      OP_TABLE: if (o < 512) begin table_m[o] = val[7:0]; table_w[o] = 1; end
      OP_DIR: begin dir_m[o] = val[7:0]; dir_w[o] = 1; end
      default: ;
    endcase
    beat_q.push_back(b);
    beats_planned++;
  endtask

  task automatic send_word(op_t op, int off, int val);
    send(op, off, val & 8'hff);
    send(op, off + 1, (val >> 8) & 8'hff);
  endtask

  task automatic send_check();
    check_result_t r;
    status_t st;
    int saves, frees;
    load_beat_t b;
    unwritten_hit = 0;
    predict_check(st, saves, frees);
    if (unwritten_hit) return;
    r.status = st;
    r.save_count = saves[8:0];
    r.free_count = frees[7:0];
    verdict_q.push_back(r);
    b.op = OP_CHECK;
    b.off = $urandom_range(0, 8191);
    b.val = $urandom_range(0, 255);
    b.wait_results = hold_next ? checks_planned : 0;
    hold_next = 0;
    beat_q.push_back(b);
    beats_planned++;
    checks_planned++;
  endtask

  task automatic damage();
    int sel, base, blk;
    sel = $urandom_range(0, 9);
    base = used_bases.size() ? used_bases[$urandom_range(0, used_bases.size() - 1)] : 0;
    blk = $urandom_range(0, word_at(0, 80) > 0 ? word_at(0, 80) - 1 : 0);
    case (sel)
      0: send(OP_ROOT, $urandom_range(0, 15), $urandom_range(0, 255));
      1: send(OP_ROOT, 70 + $urandom_range(0, 11), $urandom_range(0, 255));
      2: send(OP_DIR, base, $urandom_range(0, 255));
      3: send_word(OP_DIR, base + 24, $urandom_range(0, 1) ? 0 : $urandom_range(0, 300));
      4: send_word(OP_DIR, base + 26, $urandom_range(0, 20));
      5: send_word(OP_TABLE, blk * 2, $urandom_range(0, 1) ? END_MARK : $urandom_range(0, 40));
      6: send_word(OP_DIR, base + 2, $urandom_range(0, 40));
      7: send(OP_TABLE, $urandom_range(0, 511), $urandom_range(0, 255));
      8: send($urandom_range(0, 1) ? OP_ROOT : OP_TABLE, $urandom_range(512, 8191),
               $urandom_range(0, 255));
      default: send(OP_DIR, $urandom_range(0, 8191), $urandom_range(0, 255));
    endcase
  endtask

  task automatic build_card(int users_cap, int dlen_fix);
    int dlen, users, room, r1, r2, tpos, low, dstart, slots, files, left, len;
    int pool[$];
    int slot_order[$];
    int next_of[256];
    dlen = dlen_fix ? dlen_fix : ($urandom_range(0, 9) ? $urandom_range(1, 3)
                                                       : $urandom_range(1, 16));
    users = $urandom_range(1, (users_cap < 254 - dlen) ? users_cap : 254 - dlen);
    room = 255 - users - dlen - 1;
    r1 = $urandom_range(0, room);
    r2 = $urandom_range(0, room - r1);
    if ($urandom_range(0, 1)) begin
      tpos = users + r1;
      low = tpos + 1 + r2;
      dstart = low + dlen - 1;
    end else begin
      low = users + r1;
      dstart = low + dlen - 1;
      tpos = dstart + 1 + r2;
    end
    for (int i = 0; i < 16; i++) send(OP_ROOT, i, MARK_BYTE);
    send_word(OP_ROOT, 70, tpos);
    send_word(OP_ROOT, 72, 1);
    send_word(OP_ROOT, 74, dstart);
    send_word(OP_ROOT, 76, dlen);
    send_word(OP_ROOT, 78, $urandom_range(0, 65535));
    send_word(OP_ROOT, 80, users);
    for (int i = 0; i < users; i++) begin
      pool.push_back(i);
      next_of[i] = $urandom_range(0, 3) ? FREE_MARK : $urandom_range(0, 65535);
    end
    pool.shuffle();
    slots = dlen * 16;
    for (int i = 0; i < slots; i++) slot_order.push_back(i);
    slot_order.shuffle();
    files = $urandom_range(0, (users < 6) ? users : 6);
    if (files > slots) files = slots;
    used_bases.delete();
    for (int f = 0; f < files; f++) begin
      int base, first;
      left = pool.size() - (files - 1 - f);
      len = $urandom_range(1, left < 8 ? left : 8);
      first = pool[0];
      for (int k = 0; k < len; k++) begin
        int blk;
        blk = pool.pop_front();
        next_of[blk] = (k + 1 == len) ? END_MARK : pool[0];
      end
      base = slot_order[f] * 32;
      used_bases.push_back(base);
      send(OP_DIR, base, $urandom_range(0, 1) ? TYPE_A : TYPE_B);
      send_word(OP_DIR, base + 2, first);
      send_word(OP_DIR, base + 24, len);
      send_word(OP_DIR, base + 26, $urandom_range(0, len - 1));
    end
    for (int i = files; i < slots; i++) send(OP_DIR, slot_order[i] * 32, 0);
    for (int i = 0; i < users; i++) send_word(OP_TABLE, i * 2, next_of[i]);
    if ($urandom_range(0, 2) == 0) damage();
    send_check();
  endtask

  initial begin
    for (int i = 0; i < 256; i++) used_m[i] = 0;
    for (int i = 0; i < 15; i++) send(OP_ROOT, i, MARK_BYTE);
    send(OP_ROOT, 15, 8'h54);
    send_check();
    send(OP_ROOT, 15, MARK_BYTE);
    for (int i = 70; i < 82; i++) send(OP_ROOT, i, 0);
    send(OP_ROOT, 8191, 8'hff);
    send(OP_TABLE, 512, 8'hff);
    send_check();
    build_card(253, 1);
    hold_next = 1;
    build_card(20, 16);
    while (beats_planned < 1850) begin
      if ($urandom_range(0, 4) == 0) hold_next = 1;
      build_card($urandom_range(0, 15) ? 16 : 253, 0);
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(1, 3)) damage();
        send_check();
      end
    end
  end

  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.opcode <= '0;
      in_ch.offset <= '0;
      in_ch.byte_value <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (beat_q.size() && beat_q[0].wait_results <= results_seen) begin
        load_beat_t b;
        b = beat_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.opcode <= b.op;
        in_ch.offset <= b.off;
        in_ch.byte_value <= b.val;
        send_gap <= pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  int  take_gap = 0;
  int  long_hold = 0;
  bit  held_once = 0;

  // Counts one long stretch during which the receiver refuses results.
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold <= 0;
      held_once <= 0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end else if (!held_once && results_seen == 4) begin
      held_once <= 1;
      long_hold <= 3000;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (!verdict_q.size()) begin
          $error("result beat with no check pending");
          errors++;
        end else begin
          check_result_t e;
          e = verdict_q.pop_front();
          if (out_ch.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_ch.status);
            errors++;
          end
          if (out_ch.save_count !== e.save_count) begin
            $error("save_count expected %0d actual %0d", e.save_count, out_ch.save_count);
            errors++;
          end
          if (out_ch.free_count !== e.free_count) begin
            $error("free_count expected %0d actual %0d", e.free_count,
                   out_ch.free_count);
            errors++;
          end
        end
        results_seen <= results_seen + 1;
      end
      if (long_hold > 0) begin
        out_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        take_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    wait (beat_q.size() == 0 && !in_ch.valid && results_seen == checks_planned);
    repeat (50) @(posedge clk);
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/cfcc_pkg.sv
hw/rtl/cfcc_if.sv
hw/rtl/cfcc_datapath.sv
hw/rtl/cfcc_ctrl.sv
hw/rtl/card_filesystem_chain_checker.sv
tb/cfcc_tb_if.sv
tb/card_filesystem_chain_checker_tb.sv
